### rtl/core/mra_pkg.sv
// Shared codes and report word layout for the mouse report accumulator.
package mra_pkg;

    typedef enum logic [2:0] {
        CMD_MOVE       = 3'd0,
        CMD_BUTTON     = 3'd1,
        CMD_WHEEL      = 3'd2,
        CMD_GET_REPORT = 3'd3,
        CMD_GET_LIST   = 3'd4,
        CMD_CLEAR      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NOT_ENABLED = 2'd1,
        STATUS_BAD_PORT    = 2'd2,
        STATUS_NO_DEVICE   = 2'd3
    } t_status;

    localparam logic REG_ENABLED      = 1'b0;
    localparam logic REG_PORTS_IN_USE = 1'b1;

    typedef struct packed {
        logic              upd;
        logic [7:0]        btn;
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic signed [7:0] w;
    } t_snap;

endpackage

### rtl/core/mra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mouse_report_accumulator_unit.sv
// Mouse report accumulator: per-port state RAM, snapshot ring RAM and command sequencer.
//
//   channel   handshake                     payload
//   command   start / busy                  i_cmd, i_port, i_delta_x/y, i_button_mask,
//                                           i_pressed, i_wheel_delta
//   result    o_result_valid (one cycle)    o_status .. o_last
//   config    i_cfg_we                      i_cfg_idx, i_cfg_data
//
// Events and get/clear commands read the port entry at accept, then modify and write it back
// in the entry state. Get/clear errors found at accept answer on the next cycle, busy low;
// rejected events get no answer. A list of N reports goes through accept, entry, one
// snapshot read, then one word per cycle, bounded by the single read port of the snapshot RAM.
// Reset (i_rst_n low, synchronous) clears the port valid bits; the snapshot RAM is not cleared.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module mouse_report_accumulator_unit #(
    parameter int PORTS      = 8,
    parameter int LIST_DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [3:0]        i_cfg_data,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        i_cmd,
    input  logic [6:0]        i_port,
    input  logic signed [7:0] i_delta_x,
    input  logic signed [7:0] i_delta_y,
    input  logic [7:0]        i_button_mask,
    input  logic              i_pressed,
    input  logic signed [7:0] i_wheel_delta,
    output logic              o_result_valid,
    output logic [1:0]        o_status,
    output logic              o_updated,
    output logic [7:0]        o_buttons,
    output logic signed [7:0] o_motion_x,
    output logic signed [7:0] o_motion_y,
    output logic signed [7:0] o_wheel_motion,
    output logic [3:0]        o_list_count,
    output logic              o_record_valid,
    output logic              o_last
);

    localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int IW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW  = $clog2(LIST_DEPTH + 1);
    localparam int SD  = PORTS * LIST_DEPTH;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

    typedef struct packed {
        logic               present;
        logic               pending;
        logic [7:0]         btn;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sw;
        logic [IW-1:0]      wi;
        logic [CW-1:0]      cnt;
    } t_port_entry;

    localparam int PEW = $bits(t_port_entry);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } t_state;

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                   input logic signed [7:0] d);
        logic signed [16:0] s;
        s = 17'(a) + 17'(d);
        if (s > 17'sd32767) begin
            return 16'sh7fff;
        end else if (s < -17'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    function automatic logic signed [7:0] clamp8(input logic signed [15:0] a);
        if (a > 16'sd127) begin
            return 8'sd127;
        end else if (a < -16'sd128) begin
            return -8'sd128;
        end
        return a[7:0];
    endfunction

    // configuration
    logic       r_enabled;
    logic [3:0] r_ports_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_ports_in_use <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mra_pkg::REG_ENABLED:      r_enabled      <= i_cfg_data[0];
                mra_pkg::REG_PORTS_IN_USE: r_ports_in_use <= i_cfg_data;
                default:                   r_enabled      <= r_enabled;
            endcase
        end
    end

    // control and latched command
    t_state            r_state, n_state;
    logic [PORTS-1:0]  r_pv;
    mra_pkg::t_cmd     r_cmd;
    logic [PW-1:0]     r_port_idx;
    logic signed [7:0] r_dx, r_dy, r_wd;
    logic [7:0]        r_mask;
    logic              r_pressed;
    logic              r_entry_v;

    // result word registers
    logic              r_out_v, n_out_v;
    mra_pkg::t_status  r_out_status, n_out_status;
    mra_pkg::t_snap    r_out_rep, n_out_rep;
    logic              r_out_rec, n_out_rec;

    // list streaming
    logic [IW-1:0]     r_lidx, n_lidx;
    logic [CW-1:0]     r_issued, n_issued;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_got, n_got;
    logic              r_snap_v, n_snap_v;

    // memories
    logic              pram_we, pram_re;
    t_port_entry       pram_wdata;
    logic [PEW-1:0]    pram_rdata;
    logic              sram_we, sram_re;
    logic [SAW-1:0]    sram_waddr, sram_raddr, snap_base;
    mra_pkg::t_snap    sram_wdata;
    logic [32:0]       sram_rdata;
    mra_pkg::t_snap    snap_rd;

    logic              acc, in_range, q_ok, list_last;
    mra_pkg::t_cmd     cmd_in;
    logic [PW-1:0]     port_idx_in;
    t_port_entry       cur, upd;
    mra_pkg::t_snap    rep;
    logic [IW-1:0]     wi_next;
    logic [CW-1:0]     cnt_next;
    logic [IW+1:0]     start_tmp;
    logic [IW-1:0]     start_idx;

    assign busy        = (r_state != S_IDLE);
    assign acc         = start && !busy;
    assign cmd_in      = mra_pkg::t_cmd'(i_cmd);
    assign port_idx_in = i_port[PW-1:0];
    assign in_range    = ({1'b0, i_port} < 8'(PORTS));
    assign q_ok        = ({1'b0, i_port} < {4'd0, r_ports_in_use});
    assign pram_re     = acc;
    assign snap_base   = SAW'(r_port_idx * LIST_DEPTH);
    assign snap_rd     = mra_pkg::t_snap'(sram_rdata);
    assign list_last   = r_snap_v && ((r_got + CW'(1)) == r_total);

    mra_ram #(.WIDTH(PEW), .DEPTH(PORTS)) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (pram_we),
        .i_waddr (r_port_idx),
        .i_wdata (pram_wdata),
        .i_re    (pram_re),
        .i_raddr (port_idx_in),
        .o_rdata (pram_rdata)
    );

    mra_ram #(.WIDTH(33), .DEPTH(SD)) u_snap_ram (
        .i_clk   (i_clk),
        .i_we    (sram_we),
        .i_waddr (sram_waddr),
        .i_wdata (sram_wdata),
        .i_re    (sram_re),
        .i_raddr (sram_raddr),
        .o_rdata (sram_rdata)
    );

    // entry never written since reset reads as its reset value
    always_comb begin
        if (r_entry_v) begin
            cur = t_port_entry'(pram_rdata);
        end else begin
            cur         = '0;
            cur.present = (r_port_idx == '0);
        end
        rep.upd = cur.pending;
        rep.btn = cur.btn;
        rep.x   = clamp8(cur.sx);
        rep.y   = clamp8(cur.sy);
        rep.w   = clamp8(cur.sw);

        wi_next  = cur.wi;
        cnt_next = cur.cnt;
        if (cur.pending) begin
            wi_next = (cur.wi == IW'(LIST_DEPTH - 1)) ? '0 : cur.wi + IW'(1);
            if (cur.cnt != CW'(LIST_DEPTH)) begin
                cnt_next = cur.cnt + CW'(1);
            end
        end
        start_tmp = (IW+2)'(wi_next) + (IW+2)'(LIST_DEPTH) - (IW+2)'(cnt_next);
        if (start_tmp >= (IW+2)'(LIST_DEPTH)) begin
            start_tmp = start_tmp - (IW+2)'(LIST_DEPTH);
        end
        start_idx = start_tmp[IW-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_out_v      = 1'b0;
        n_out_status = mra_pkg::STATUS_OK;
        n_out_rep    = '0;
        n_out_rec    = 1'b0;
        n_lidx       = r_lidx;
        n_issued     = r_issued;
        n_total      = r_total;
        n_got        = r_got;
        n_snap_v     = 1'b0;
        pram_we      = 1'b0;
        upd          = cur;
        sram_we      = 1'b0;
        sram_waddr   = snap_base + SAW'(cur.wi);
        sram_wdata   = rep;
        sram_re      = 1'b0;
        sram_raddr   = snap_base + SAW'(r_lidx);

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (cmd_in)
                        mra_pkg::CMD_MOVE, mra_pkg::CMD_BUTTON, mra_pkg::CMD_WHEEL: begin
                            if (r_enabled && in_range) begin
                                n_state = S_EXEC;
                            end
                        end
                        mra_pkg::CMD_GET_REPORT, mra_pkg::CMD_GET_LIST,
                        mra_pkg::CMD_CLEAR: begin
                            if (!r_enabled) begin
                                n_out_v      = 1'b1;
                                n_out_status = mra_pkg::STATUS_NOT_ENABLED;
                            end else if (!in_range ||
                                         (cmd_in != mra_pkg::CMD_CLEAR && !q_ok)) begin
                                n_out_v      = 1'b1;
                                n_out_status = mra_pkg::STATUS_BAD_PORT;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_cmd)
                    mra_pkg::CMD_MOVE: begin
                        upd.present = 1'b1;
                        upd.pending = 1'b1;
                        upd.sx      = sat_add(cur.sx, r_dx);
                        upd.sy      = sat_add(cur.sy, r_dy);
                        pram_we     = 1'b1;
                    end
                    mra_pkg::CMD_BUTTON: begin
                        upd.present = 1'b1;
                        upd.pending = 1'b1;
                        upd.btn     = r_pressed ? (cur.btn | r_mask) : (cur.btn & ~r_mask);
                        pram_we     = 1'b1;
                    end
                    mra_pkg::CMD_WHEEL: begin
                        upd.present = 1'b1;
                        upd.pending = 1'b1;
                        upd.sw      = sat_add(cur.sw, r_wd);
                        pram_we     = 1'b1;
                    end
                    mra_pkg::CMD_CLEAR: begin
                        upd.sx      = '0;
                        upd.sy      = '0;
                        upd.sw      = '0;
                        upd.pending = 1'b0;
                        upd.wi      = '0;
                        upd.cnt     = '0;
                        pram_we     = 1'b1;
                        n_out_v     = 1'b1;
                    end
                    mra_pkg::CMD_GET_REPORT: begin
                        n_out_v = 1'b1;
                        if (!cur.present) begin
                            n_out_status = mra_pkg::STATUS_NO_DEVICE;
                        end else begin
                            upd.sx      = '0;
                            upd.sy      = '0;
                            upd.sw      = '0;
                            upd.pending = 1'b0;
                            pram_we     = 1'b1;
                            n_out_rep   = rep;
                            n_out_rec   = 1'b1;
                        end
                    end
                    mra_pkg::CMD_GET_LIST: begin
                        if (!cur.present) begin
                            n_out_v      = 1'b1;
                            n_out_status = mra_pkg::STATUS_NO_DEVICE;
                        end else begin
                            // snapshot a pending report, then empty the ring
                            sram_we = cur.pending;
                            if (cur.pending) begin
                                upd.sx      = '0;
                                upd.sy      = '0;
                                upd.sw      = '0;
                                upd.pending = 1'b0;
                            end
                            upd.wi  = '0;
                            upd.cnt = '0;
                            pram_we = 1'b1;
                            if (cnt_next == '0) begin
                                n_out_v = 1'b1;
                            end else begin
                                n_state  = S_LIST;
                                n_lidx   = start_idx;
                                n_issued = '0;
                                n_total  = cnt_next;
                                n_got    = '0;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_LIST: begin
                if (r_issued != r_total) begin
                    sram_re  = 1'b1;
                    n_snap_v = 1'b1;
                    n_issued = r_issued + CW'(1);
                    n_lidx   = (r_lidx == IW'(LIST_DEPTH - 1)) ? '0 : r_lidx + IW'(1);
                end
                if (r_snap_v) begin
                    n_got = r_got + CW'(1);
                end
                if (list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        pram_wdata = upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= '0;
            r_out_v  <= 1'b0;
            r_snap_v <= 1'b0;
            r_issued <= '0;
            r_total  <= '0;
            r_got    <= '0;
        end else begin
            r_state  <= n_state;
            r_out_v  <= n_out_v;
            r_snap_v <= n_snap_v;
            r_issued <= n_issued;
            r_total  <= n_total;
            r_got    <= n_got;
            if (pram_we) begin
                r_pv[r_port_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_rep    <= n_out_rep;
        r_out_rec    <= n_out_rec;
        r_lidx       <= n_lidx;
        if (acc) begin
            r_cmd      <= cmd_in;
            r_port_idx <= port_idx_in;
            r_dx       <= i_delta_x;
            r_dy       <= i_delta_y;
            r_wd       <= i_wheel_delta;
            r_mask     <= i_button_mask;
            r_pressed  <= i_pressed;
            r_entry_v  <= r_pv[port_idx_in];
        end
    end

    // list words come straight from the registered snapshot read port
    assign o_result_valid = r_out_v || r_snap_v;
    assign o_status       = r_snap_v ? mra_pkg::STATUS_OK : r_out_status;
    assign o_updated      = r_snap_v ? snap_rd.upd : r_out_rep.upd;
    assign o_buttons      = r_snap_v ? snap_rd.btn : r_out_rep.btn;
    assign o_motion_x     = r_snap_v ? snap_rd.x   : r_out_rep.x;
    assign o_motion_y     = r_snap_v ? snap_rd.y   : r_out_rep.y;
    assign o_wheel_motion = r_snap_v ? snap_rd.w   : r_out_rep.w;
    assign o_list_count   = r_snap_v ? 4'(r_total) : 4'd0;
    assign o_record_valid = r_snap_v ? 1'b1        : r_out_rec;
    assign o_last         = r_snap_v ? list_last   : r_out_v;

`ifndef NO_ASSERTIONS
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_v && r_snap_v))
        else $error("result word driven from two sources");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_issued <= r_total) && (r_got <= r_issued))
        else $error("list read count out of bounds");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_v && o_last) |=> !busy)
        else $error("sequencer still busy after final list word");

    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $past(start && !busy))
        else $error("entry cycle without an accepted command");
`endif

endmodule

### tb/tb_mouse_report_accumulator_unit.sv
// Testbench for the mouse report accumulator: directed and random words against a predictor.
module tb_mouse_report_accumulator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_PORTS       = 8;
    localparam int RING_DEPTH    = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 40;

    // command codes the block does not define
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]        cmd;
        logic [6:0]        port;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic [7:0]        mask;
        logic              pressed;
        logic signed [7:0] wd;
    } t_cmd_word;

    typedef struct {
        logic [1:0] status;
        logic       updated;
        logic [7:0] buttons;
        logic [7:0] mx;
        logic [7:0] my;
        logic [7:0] mw;
        logic [3:0] count;
        logic       rvalid;
        logic       last;
    } t_reply;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic              i_cfg_idx      = 1'b0;
    logic [3:0]        i_cfg_data     = '0;
    logic              start          = 1'b0;
    logic              busy;
    logic [2:0]        i_cmd          = '0;
    logic [6:0]        i_port         = '0;
    logic signed [7:0] i_delta_x      = '0;
    logic signed [7:0] i_delta_y      = '0;
    logic [7:0]        i_button_mask  = '0;
    logic              i_pressed      = 1'b0;
    logic signed [7:0] i_wheel_delta  = '0;
    logic              o_result_valid;
    logic [1:0]        o_status;
    logic              o_updated;
    logic [7:0]        o_buttons;
    logic signed [7:0] o_motion_x;
    logic signed [7:0] o_motion_y;
    logic signed [7:0] o_wheel_motion;
    logic [3:0]        o_list_count;
    logic              o_record_valid;
    logic              o_last;

    mouse_report_accumulator_unit #(
        .PORTS      (N_PORTS),
        .LIST_DEPTH (RING_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_port         (i_port),
        .i_delta_x      (i_delta_x),
        .i_delta_y      (i_delta_y),
        .i_button_mask  (i_button_mask),
        .i_pressed      (i_pressed),
        .i_wheel_delta  (i_wheel_delta),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_updated      (o_updated),
        .o_buttons      (o_buttons),
        .o_motion_x     (o_motion_x),
        .o_motion_y     (o_motion_y),
        .o_wheel_motion (o_wheel_motion),
        .o_list_count   (o_list_count),
        .o_record_valid (o_record_valid),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the block state and registers
    logic           cfg_enabled;
    logic [3:0]     cfg_ports;
    logic           present    [N_PORTS];
    logic [7:0]     btn_state  [N_PORTS];
    int             sum_x      [N_PORTS];
    int             sum_y      [N_PORTS];
    int             sum_wheel  [N_PORTS];
    logic           pend       [N_PORTS];
    mra_pkg::t_snap ring_store [N_PORTS][RING_DEPTH];
    int             wr_idx     [N_PORTS];
    int             fill_level [N_PORTS];

    t_reply reply_q[$];

    int mismatches      = 0;
    int words_accepted  = 0;
    int replies_checked = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;
    int burst_left      = 0;

    function automatic int sat16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [7:0] clamp8(input int v);
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return v[7:0];
    endfunction

    function automatic mra_pkg::t_snap take_snap(input int p);
        mra_pkg::t_snap s;
        s.upd = pend[p];
        s.btn = btn_state[p];
        s.x   = clamp8(sum_x[p]);
        s.y   = clamp8(sum_y[p]);
        s.w   = clamp8(sum_wheel[p]);
        sum_x[p]     = 0;
        sum_y[p]     = 0;
        sum_wheel[p] = 0;
        pend[p]      = 1'b0;
        return s;
    endfunction

    function automatic void push_reply(input mra_pkg::t_status st, input mra_pkg::t_snap s,
                                       input int cnt, input logic rv, input logic lst);
        t_reply r;
        r.status  = st;
        r.updated = s.upd;
        r.buttons = s.btn;
        r.mx      = s.x;
        r.my      = s.y;
        r.mw      = s.w;
        r.count   = cnt[3:0];
        r.rvalid  = rv;
        r.last    = lst;
        reply_q.push_back(r);
    endfunction

    function automatic void apply_command(input t_cmd_word w);
        int p;
        int lim;
        int n;
        int first;
        int i;
        p   = int'(w.port);
        lim = (int'(cfg_ports) < N_PORTS) ? int'(cfg_ports) : N_PORTS;
        if (w.cmd <= mra_pkg::CMD_WHEEL) begin
            if (!cfg_enabled || p >= N_PORTS) return;
            present[p] = 1'b1;
            if (w.cmd == mra_pkg::CMD_MOVE) begin
                sum_x[p] = sat16(sum_x[p] + int'(w.dx));
                sum_y[p] = sat16(sum_y[p] + int'(w.dy));
            end else if (w.cmd == mra_pkg::CMD_BUTTON) begin
                if (w.pressed) btn_state[p] |= w.mask;
                else btn_state[p] &= ~w.mask;
            end else begin
                sum_wheel[p] = sat16(sum_wheel[p] + int'(w.wd));
            end
            pend[p] = 1'b1;
            return;
        end
        if (w.cmd > mra_pkg::CMD_CLEAR) return;
        if (!cfg_enabled) begin
            push_reply(mra_pkg::STATUS_NOT_ENABLED, '0, 0, 1'b0, 1'b1);
            return;
        end
        if (w.cmd == mra_pkg::CMD_CLEAR) begin
            if (p >= N_PORTS) begin
                push_reply(mra_pkg::STATUS_BAD_PORT, '0, 0, 1'b0, 1'b1);
                return;
            end
            sum_x[p]      = 0;
            sum_y[p]      = 0;
            sum_wheel[p]  = 0;
            pend[p]       = 1'b0;
            fill_level[p] = 0;
            wr_idx[p]     = 0;
            push_reply(mra_pkg::STATUS_OK, '0, 0, 1'b0, 1'b1);
            return;
        end
        if (p >= lim) begin
            push_reply(mra_pkg::STATUS_BAD_PORT, '0, 0, 1'b0, 1'b1);
            return;
        end
        if (!present[p]) begin
            push_reply(mra_pkg::STATUS_NO_DEVICE, '0, 0, 1'b0, 1'b1);
            return;
        end
        if (w.cmd == mra_pkg::CMD_GET_REPORT) begin
            push_reply(mra_pkg::STATUS_OK, take_snap(p), 0, 1'b1, 1'b1);
            return;
        end
        // snapshot a pending report into the ring, then stream the ring oldest first
        if (pend[p]) begin
            ring_store[p][wr_idx[p]] = take_snap(p);
            wr_idx[p] = (wr_idx[p] + 1) % RING_DEPTH;
            if (fill_level[p] < RING_DEPTH) fill_level[p]++;
        end
        n = fill_level[p];
        if (n == 0) begin
            push_reply(mra_pkg::STATUS_OK, '0, 0, 1'b0, 1'b1);
            return;
        end
        first = (wr_idx[p] + RING_DEPTH - n) % RING_DEPTH;
        for (i = 0; i < n; i++) begin
            push_reply(mra_pkg::STATUS_OK, ring_store[p][(first + i) % RING_DEPTH], n, 1'b1,
                       (i + 1 == n));
        end
        fill_level[p] = 0;
        wr_idx[p]     = 0;
    endfunction

    function automatic t_cmd_word mk(input logic [2:0] cmd, input int port, input int dx,
                                     input int dy, input int mask, input int pressed,
                                     input int wd);
        t_cmd_word w;
        w.cmd     = cmd;
        w.port    = port[6:0];
        w.dx      = dx[7:0];
        w.dy      = dy[7:0];
        w.mask    = mask[7:0];
        w.pressed = pressed[0];
        w.wd      = wd[7:0];
        return w;
    endfunction

    function automatic t_cmd_word random_word(input logic [2:0] cmd, input int port);
        return mk(cmd, port, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Drive one command word and hold it until the block takes it.
    task automatic send_word(input t_cmd_word w);
        i_cmd         <= w.cmd;
        i_port        <= w.port;
        i_delta_x     <= w.dx;
        i_delta_y     <= w.dy;
        i_button_mask <= w.mask;
        i_pressed     <= w.pressed;
        i_wheel_delta <= w.wd;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_command(w);
        words_accepted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Wait out every outstanding reply and the tail of any event still in flight.
    task automatic drain_replies();
        start <= 1'b0;
        while (reply_q.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [3:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == mra_pkg::REG_ENABLED) cfg_enabled = data[0];
        else cfg_ports = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic en, input logic [3:0] ports);
        logic [2:0] junk;
        junk = 3'($urandom);
        drain_replies();
        // only bit 0 of the enable word counts
        write_register(mra_pkg::REG_ENABLED, {junk, en});
        write_register(mra_pkg::REG_PORTS_IN_USE, ports);
        settings_used++;
    endtask

    task automatic test_disabled();
        send_word(mk(mra_pkg::CMD_MOVE, 0, 10, 10, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_LIST, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 127, 0, 0, 0, 0, 0));
        send_word(mk(CMD_SPARE_HI, 0, 0, 0, 0, 0, 0));
        apply_setting(1'b1, 4'd8);
        // the move above must have been dropped
        send_word(mk(mra_pkg::CMD_GET_REPORT, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_directed();
        send_word(mk(mra_pkg::CMD_GET_REPORT, 1, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 8, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_LIST, 127, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 0, 127, -128, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 0, 127, -128, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_BUTTON, 1, 0, 0, 8'hFF, 1, 0));
        send_word(mk(mra_pkg::CMD_BUTTON, 1, 0, 0, 8'h55, 0, 0));
        send_word(mk(mra_pkg::CMD_WHEEL, 1, 0, 0, 0, 0, -128));
        send_word(mk(mra_pkg::CMD_WHEEL, 1, 0, 0, 0, 0, 127));
        send_word(mk(mra_pkg::CMD_GET_LIST, 1, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_LIST, 1, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 127, 1, 1, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 8, 1, 1, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 7, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 8, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 6, 0, 0, 0, 0, 0));
        // clear keeps buttons and presence
        send_word(mk(mra_pkg::CMD_BUTTON, 2, 0, 0, 8'h81, 1, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 2, 5, 5, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 2, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 2, 0, 0, 0, 0, 0));
        send_word(mk(CMD_SPARE_LO, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 0, -128, 127, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_WHEEL, 0, 0, 0, 0, 0, -1));
        send_word(mk(mra_pkg::CMD_GET_LIST, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_port_limit();
        apply_setting(1'b1, 4'd0);
        send_word(mk(mra_pkg::CMD_GET_REPORT, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_LIST, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_MOVE, 5, 3, -3, 0, 0, 0));
        apply_setting(1'b1, 4'd15);
        send_word(mk(mra_pkg::CMD_GET_REPORT, 5, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 7, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_LIST, 8, 0, 0, 0, 0, 0));
        apply_setting(1'b1, 4'd3);
        send_word(mk(mra_pkg::CMD_GET_REPORT, 2, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 3, 0, 0, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_WHEEL, 3, 0, 0, 0, 0, 5));
        apply_setting(1'b1, 4'd4);
        send_word(mk(mra_pkg::CMD_GET_LIST, 3, 0, 0, 0, 0, 0));
    endtask

    // Push both move sums past their rails; a wrapped sum would flip the report sign.
    task automatic test_saturation();
        apply_setting(1'b1, 4'd8);
        repeat (260) send_word(mk(mra_pkg::CMD_MOVE, 4, 127, -128, 0, 0, 0));
        send_word(mk(mra_pkg::CMD_GET_REPORT, 4, 0, 0, 0, 0, 0));
    endtask

    // Mostly event runs on one port closed by a query, with some noise words.
    task automatic run_random_phase(input int n_words);
        int sent;
        int p;
        int span;
        int r;
        logic [2:0] query;
        sent = 0;
        while (sent < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                if (r < 4)
                    send_word(random_word(3'($urandom_range(6, 7)), $urandom_range(0, 127)));
                else
                    send_word(random_word(3'($urandom_range(0, 5)), $urandom_range(0, 127)));
                sent++;
            end else begin
                span = (cfg_ports == 0) ? 1 : ((cfg_ports > N_PORTS) ? N_PORTS : cfg_ports);
                p = $urandom_range(0, span - 1);
                if ($urandom_range(0, 9) == 0) p = $urandom_range(0, N_PORTS - 1);
                repeat ($urandom_range(0, 4)) begin
                    send_word(random_word(3'($urandom_range(0, 2)), p));
                    sent++;
                end
                r = $urandom_range(0, 9);
                query = (r < 5) ? mra_pkg::CMD_GET_REPORT
                                : ((r < 9) ? mra_pkg::CMD_GET_LIST : mra_pkg::CMD_CLEAR);
                send_word(random_word(query, p));
                sent++;
            end
        end
    endtask

    task automatic test_random();
        apply_setting(1'b1, 4'd8);
        run_random_phase(30);
        apply_setting(1'b1, 4'd3);
        run_random_phase(25);
        apply_setting(1'b1, 4'd0);
        run_random_phase(10);
        apply_setting(1'b0, 4'd8);
        run_random_phase(10);
        apply_setting(1'b1, 4'd15);
        run_random_phase(30);
        apply_setting(1'b1, 4'd1);
        run_random_phase(20);
        apply_setting(1'b1, 4'd8);
        run_random_phase(40);
    endtask

    always @(posedge i_clk) begin : check_replies
        t_reply got;
        t_reply want;
        if (i_rst_n && o_result_valid) begin
            got.status  = o_status;
            got.updated = o_updated;
            got.buttons = o_buttons;
            got.mx      = o_motion_x;
            got.my      = o_motion_y;
            got.mw      = o_wheel_motion;
            got.count   = o_list_count;
            got.rvalid  = o_record_valid;
            got.last    = o_last;
            replies_checked++;
            if (reply_q.size() == 0) begin
                report_mismatch("reply word with nothing outstanding", 1, 0);
            end else begin
                want = reply_q.pop_front();
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.updated !== want.updated)
                    report_mismatch("updated", got.updated, want.updated);
                if (got.buttons !== want.buttons)
                    report_mismatch("buttons", got.buttons, want.buttons);
                if (got.mx !== want.mx) report_mismatch("motion_x", got.mx, want.mx);
                if (got.my !== want.my) report_mismatch("motion_y", got.my, want.my);
                if (got.mw !== want.mw) report_mismatch("wheel_motion", got.mw, want.mw);
                if (got.count !== want.count)
                    report_mismatch("list_count", got.count, want.count);
                if (got.rvalid !== want.rvalid)
                    report_mismatch("record_valid", got.rvalid, want.rvalid);
                if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid === 1'b1 || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        cfg_enabled = 1'b0;
        cfg_ports   = 4'd1;
        for (int i = 0; i < N_PORTS; i++) begin
            present[i]    = (i == 0);
            btn_state[i]  = '0;
            sum_x[i]      = 0;
            sum_y[i]      = 0;
            sum_wheel[i]  = 0;
            pend[i]       = 1'b0;
            wr_idx[i]     = 0;
            fill_level[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_disabled();
        test_directed();
        test_port_limit();
        test_saturation();
        test_random();
        drain_replies();

        $display("summary: %0d command words accepted, %0d reply words checked",
                 words_accepted, replies_checked);
        $display("summary: %0d register settings, events, queries, clears and sum clipping",
                 settings_used);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### mouse_report_accumulator_unit.f
rtl/core/mra_pkg.sv
rtl/core/mra_ram.sv
rtl/core/mouse_report_accumulator_unit.sv
tb/tb_mouse_report_accumulator_unit.sv
